// ===== rtl/kpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kpc_pkg;

	localparam int NUM_KEYS  = 3;
	localparam int CODE_W    = 3;
	localparam int TICK_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUPER    = 2'd3;

	localparam logic [NUM_KEYS-1:0] ENABLE_RST   = 3'd7;
	localparam logic [NUM_KEYS-1:0] POLARITY_RST = 3'd4;
	localparam logic [TICK_W-1:0]   LONG_RST     = 8'd30;
	localparam logic [TICK_W-1:0]   SUPER_RST    = 8'd100;

	// event codes
	localparam logic [CODE_W-1:0] EV_NONE  = 3'd0;
	localparam logic [CODE_W-1:0] EV_DOWN  = 3'd1;
	localparam logic [CODE_W-1:0] EV_LONG  = 3'd2;
	localparam logic [CODE_W-1:0] EV_SUPER = 3'd3;
	localparam logic [CODE_W-1:0] EV_UP    = 3'd4;

	typedef struct packed {
		logic [CODE_W-1:0] evt;
		logic [CODE_W-1:0] state;
	} lane_out_t;

endpackage

`default_nettype wire

// ===== rtl/kpc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpc_lane (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire logic                          pin,
	input  wire logic                          enable,
	input  wire logic                          polarity,
	input  wire logic [kpc_pkg::TICK_W-1:0]    long_ticks,
	input  wire logic [kpc_pkg::TICK_W-1:0]    super_ticks,
	output kpc_pkg::lane_out_t                 lane_o
);

	typedef enum logic [kpc_pkg::CODE_W-1:0] {
		S_IDLE    = 3'd0,
		S_CONFIRM = 3'd1,
		S_DOWN    = 3'd2,
		S_LONG    = 3'd3,
		S_SUPER   = 3'd4
	} state_t;

	state_t                       state_q, state_d;
	logic [kpc_pkg::TICK_W-1:0]   count_q, count_d, count_inc;
	logic                         level_q, level_d;
	logic [kpc_pkg::CODE_W-1:0]   evt_d;

	assign level_d   = enable ? (pin == polarity) : level_q;
	assign count_inc = count_q + 8'd1;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		evt_d   = kpc_pkg::EV_NONE;
		case (state_q)
			S_CONFIRM: begin
				if (level_d) begin
					state_d = S_DOWN;
					count_d = '0;
					evt_d   = kpc_pkg::EV_DOWN;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DOWN: begin
				if (!level_d) begin
					state_d = S_IDLE;
					evt_d   = kpc_pkg::EV_UP;
				end else if (count_inc >= long_ticks) begin
					state_d = S_LONG;
					count_d = '0;
					evt_d   = kpc_pkg::EV_LONG;
				end else begin
					count_d = count_inc;
				end
			end
			S_LONG, S_SUPER: begin
				if (!level_d) begin
					state_d = S_IDLE;
					evt_d   = kpc_pkg::EV_UP;
				end else if (count_inc >= super_ticks) begin
					// repeat every super-long period while held
					state_d = S_SUPER;
					count_d = '0;
					evt_d   = kpc_pkg::EV_SUPER;
				end else begin
					count_d = count_inc;
				end
			end
			default: begin
				state_d = level_d ? S_CONFIRM : S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			level_q <= 1'b0;
		end else if (advance) begin
			state_q <= state_d;
			count_q <= count_d;
			level_q <= level_d;
		end
	end

	assign lane_o.evt   = evt_d;
	assign lane_o.state = state_d;

	a_down_enters_down: assert property (@(posedge clk) disable iff (!arst_n)
		advance && evt_d == kpc_pkg::EV_DOWN |=> state_q == S_DOWN && count_q == '0)
		else $error("down item did not enter down state");

	a_up_enters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && evt_d == kpc_pkg::EV_UP |=> state_q == S_IDLE)
		else $error("up item did not return to idle");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> evt_d == kpc_pkg::EV_NONE)
		else $error("event raised from idle");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q) && $stable(count_q) && $stable(level_q))
		else $error("lane state moved without an item");

endmodule

`default_nettype wire

// ===== rtl/kpc_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpc_merge (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            advance,
	input  wire logic                                            out_ready,
	input  wire kpc_pkg::lane_out_t [kpc_pkg::NUM_KEYS-1:0]      lanes,
	output logic                                                 out_valid,
	output logic [kpc_pkg::NUM_KEYS*kpc_pkg::CODE_W-1:0]        key_events,
	output logic [kpc_pkg::NUM_KEYS*kpc_pkg::CODE_W-1:0]        key_states
);

	logic [kpc_pkg::NUM_KEYS*kpc_pkg::CODE_W-1:0] events_d, states_d;

	always_comb begin
		for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
			events_d[k*kpc_pkg::CODE_W +: kpc_pkg::CODE_W] = lanes[k].evt;
			states_d[k*kpc_pkg::CODE_W +: kpc_pkg::CODE_W] = lanes[k].state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// payload loads only with a new item
	always_ff @(posedge clk) begin
		if (advance) begin
			key_events <= events_d;
			key_states <= states_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/key_press_classifier.sv =====
// The result is valid on the output register in the cycle after the item is accepted.
// Throughput: one item per cycle; a new item is taken in the same cycle the
// previous result leaves, so the output register sets the pace.
// Reset (arst_n low, asynchronous): all keys idle, hold counters and pressed
// levels cleared, registers back to enable 7, polarity 4, long 30, super 100.
`timescale 1ns / 1ps
`default_nettype none

module key_press_classifier (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             cfg_we,
	input  wire logic [kpc_pkg::CFG_IDX_W-1:0]                    cfg_index,
	input  wire logic [kpc_pkg::CFG_W-1:0]                        cfg_data,
	input  wire logic                                             in_valid,
	output logic                                                  in_ready,
	input  wire logic [kpc_pkg::NUM_KEYS-1:0]                     pin_levels,
	output logic                                                  out_valid,
	input  wire logic                                             out_ready,
	output logic [kpc_pkg::NUM_KEYS*kpc_pkg::CODE_W-1:0]         key_events,
	output logic [kpc_pkg::NUM_KEYS*kpc_pkg::CODE_W-1:0]         key_states
);

	logic [kpc_pkg::NUM_KEYS-1:0]  enable_q, polarity_q;
	logic [kpc_pkg::TICK_W-1:0]    long_q, super_q;
	logic                          advance;
	kpc_pkg::lane_out_t [kpc_pkg::NUM_KEYS-1:0] lanes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= kpc_pkg::ENABLE_RST;
			polarity_q <= kpc_pkg::POLARITY_RST;
			long_q     <= kpc_pkg::LONG_RST;
			super_q    <= kpc_pkg::SUPER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kpc_pkg::REG_ENABLE:   enable_q   <= cfg_data[kpc_pkg::NUM_KEYS-1:0];
				kpc_pkg::REG_POLARITY: polarity_q <= cfg_data[kpc_pkg::NUM_KEYS-1:0];
				kpc_pkg::REG_LONG:     long_q     <= cfg_data[kpc_pkg::TICK_W-1:0];
				kpc_pkg::REG_SUPER:    super_q    <= cfg_data[kpc_pkg::TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !out_valid || out_ready;
	assign advance  = in_valid && in_ready;

	for (genvar k = 0; k < kpc_pkg::NUM_KEYS; k++) begin : g_lane
		kpc_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.advance     (advance),
			.pin         (pin_levels[k]),
			.enable      (enable_q[k]),
			.polarity    (polarity_q[k]),
			.long_ticks  (long_q),
			.super_ticks (super_q),
			.lane_o      (lanes[k])
		);
	end

	kpc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.out_ready  (out_ready),
		.lanes      (lanes),
		.out_valid  (out_valid),
		.key_events (key_events),
		.key_states (key_states)
	);

endmodule

`default_nettype wire

// ===== verif/key_press_checker.sv =====
`timescale 1ns / 1ps

module key_press_checker
	import kpc_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]             cfg_data,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [NUM_KEYS-1:0]          pin_levels,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [NUM_KEYS*CODE_W-1:0]   key_events,
	input  wire logic [NUM_KEYS*CODE_W-1:0]   key_states,
	output int                                pending,
	output int                                fails
);

	typedef enum logic [CODE_W-1:0] {
		MODE_IDLE    = 3'd0,
		MODE_CONFIRM = 3'd1,
		MODE_DOWN    = 3'd2,
		MODE_LONG    = 3'd3,
		MODE_SUPER   = 3'd4
	} key_mode_t;

	typedef struct packed {
		logic [NUM_KEYS*CODE_W-1:0] events;
		logic [NUM_KEYS*CODE_W-1:0] states;
	} tick_result_t;

	logic [NUM_KEYS-1:0] enable_mask;
	logic [NUM_KEYS-1:0] polarity_mask;
	logic [TICK_W-1:0]   long_limit;
	logic [TICK_W-1:0]   super_limit;

	key_mode_t           key_mode [NUM_KEYS];
	logic [TICK_W-1:0]   hold_ticks [NUM_KEYS];
	logic                held [NUM_KEYS];

	tick_result_t        expected_ticks [$];
	tick_result_t        oldest;
	int                  mismatches;

	function automatic tick_result_t classify_tick(input logic [NUM_KEYS-1:0] pins);
		tick_result_t      res;
		logic [CODE_W-1:0] code;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (enable_mask[k])
				held[k] = (pins[k] == polarity_mask[k]);
		end
		for (int k = 0; k < NUM_KEYS; k++) begin
			code = EV_NONE;
			case (key_mode[k])
				MODE_CONFIRM: begin
					if (held[k]) begin
						code = EV_DOWN;
						key_mode[k] = MODE_DOWN;
						hold_ticks[k] = '0;
					end else begin
						// release before confirmation: silent return to idle
						key_mode[k] = MODE_IDLE;
					end
				end
				MODE_DOWN: begin
					if (!held[k]) begin
						code = EV_UP;
						key_mode[k] = MODE_IDLE;
					end else begin
						hold_ticks[k] = hold_ticks[k] + 1'b1;
						if (hold_ticks[k] >= long_limit) begin
							code = EV_LONG;
							key_mode[k] = MODE_LONG;
							hold_ticks[k] = '0;
						end
					end
				end
				MODE_LONG, MODE_SUPER: begin
					if (!held[k]) begin
						code = EV_UP;
						key_mode[k] = MODE_IDLE;
					end else begin
						hold_ticks[k] = hold_ticks[k] + 1'b1;
						if (hold_ticks[k] >= super_limit) begin
							code = EV_SUPER;
							key_mode[k] = MODE_SUPER;
							hold_ticks[k] = '0;
						end
					end
				end
				default: key_mode[k] = held[k] ? MODE_CONFIRM : MODE_IDLE;
			endcase
			res.events[CODE_W*k +: CODE_W] = code;
			res.states[CODE_W*k +: CODE_W] = key_mode[k];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input tick_result_t want);
		if (mismatches < 10)
			$display("%0t key_press_checker: %s: expected events %h states %h,",
				$realtime, what, want.events, want.states,
				" got events %h states %h", key_events, key_states);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask   = ENABLE_RST;
			polarity_mask = POLARITY_RST;
			long_limit    = LONG_RST;
			super_limit   = SUPER_RST;
			for (int k = 0; k < NUM_KEYS; k++) begin
				key_mode[k]   = MODE_IDLE;
				hold_ticks[k] = '0;
				held[k]       = 1'b0;
			end
			expected_ticks.delete();
			mismatches = 0;
			pending <= 0;
			fails   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_ticks.size() == 0) begin
					report_mismatch("result with no item outstanding", '0);
				end else begin
					oldest = expected_ticks.pop_front();
					if (oldest.events !== key_events || oldest.states !== key_states)
						report_mismatch("result mismatch", oldest);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE:   enable_mask   = cfg_data[NUM_KEYS-1:0];
					REG_POLARITY: polarity_mask = cfg_data[NUM_KEYS-1:0];
					REG_LONG:     long_limit    = cfg_data[TICK_W-1:0];
					REG_SUPER:    super_limit   = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_ticks.push_back(classify_tick(pin_levels));
			pending <= expected_ticks.size();
			fails   <= mismatches;
		end
	end

endmodule

// ===== verif/tb_key_press_classifier.sv =====
`timescale 1ns / 1ps

module tb_key_press_classifier;
	import kpc_pkg::*;

	localparam int WATCHDOG_CYCLES = 400;
	localparam int HOLD_CAP        = 600;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index  = '0;
	logic [CFG_W-1:0]           cfg_data   = '0;
	logic                       in_valid   = 1'b0;
	logic [NUM_KEYS-1:0]        pin_levels = '0;
	logic                       out_ready  = 1'b0;
	logic                       in_ready;
	logic                       out_valid;
	logic [NUM_KEYS*CODE_W-1:0] key_events;
	logic [NUM_KEYS*CODE_W-1:0] key_states;
	int                         pending;
	int                         fails;

	// stimulus shaping: current register values and per-key press runs
	logic [NUM_KEYS-1:0]        cur_pol   = POLARITY_RST;
	int                         cur_long  = LONG_RST;
	int                         cur_super = SUPER_RST;
	int                         run_left [NUM_KEYS];
	logic                       run_on [NUM_KEYS];
	int                         busy_pct  = 20;
	int                         stall_left = 0;
	int                         quiet_cycles = 0;

	key_press_classifier u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pin_levels (pin_levels),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_events (key_events),
		.key_states (key_states)
	);

	key_press_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pin_levels (pin_levels),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_events (key_events),
		.key_states (key_states),
		.pending    (pending),
		.fails      (fails)
	);

	always #5 clk = ~clk;

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (busy_pct > 0 && $urandom_range(0, 99) < busy_pct)
			stall_left = $urandom_range(1, 8);
		out_ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("tb_key_press_classifier failed");
			$finish;
		end
	end

	function automatic logic [NUM_KEYS-1:0] pins_for(input logic [NUM_KEYS-1:0] pressed);
		return pressed ~^ cur_pol;
	endfunction

	function automatic logic [NUM_KEYS-1:0] next_pins();
		logic [NUM_KEYS-1:0] want;
		int                  cap;
		cap = cur_long + 3 * cur_super + 4;
		if (cap > HOLD_CAP)
			cap = HOLD_CAP;
		// occasional glitch item
		if ($urandom_range(0, 9) == 0)
			return NUM_KEYS'($urandom);
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (run_left[k] == 0) begin
				run_on[k] = !run_on[k];
				if (run_on[k]) begin
					case ($urandom_range(0, 3))
						0: run_left[k] = $urandom_range(1, 3);
						1: run_left[k] = $urandom_range(1, cur_long + 2);
						default: run_left[k] = $urandom_range(cur_long + 1, cap);
					endcase
				end else begin
					run_left[k] = $urandom_range(1, 6);
				end
			end
			run_left[k]--;
			want[k] = run_on[k];
		end
		return pins_for(want);
	endfunction

	task automatic send_tick(input logic [NUM_KEYS-1:0] pins);
		int gap;
		if (busy_pct > 0 && $urandom_range(0, 99) < busy_pct) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		pin_levels <= pins;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold the sender until every outstanding result is out, then let the pipe empty
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_setting(input logic [NUM_KEYS-1:0] en, input logic [NUM_KEYS-1:0] pol,
		input logic [TICK_W-1:0] lng, input logic [TICK_W-1:0] sup);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ENABLE;
		cfg_data  <= {5'($urandom), en};
		@(posedge clk);
		cfg_index <= REG_POLARITY;
		cfg_data  <= {5'($urandom), pol};
		@(posedge clk);
		cfg_index <= REG_LONG;
		cfg_data  <= lng;
		@(posedge clk);
		cfg_index <= REG_SUPER;
		cfg_data  <= sup;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_pol   = pol;
		cur_long  = lng;
		cur_super = sup;
	endtask

	initial begin
		logic [NUM_KEYS-1:0] en;
		logic [NUM_KEYS-1:0] pol;
		logic [TICK_W-1:0]   lng;
		logic [TICK_W-1:0]   sup;
		int                  n;
		for (int k = 0; k < NUM_KEYS; k++) begin
			run_left[k] = 0;
			run_on[k]   = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: release in confirm, down, up, raw pin extremes
		send_tick(pins_for(3'b000));
		send_tick(pins_for(3'b111));
		send_tick(pins_for(3'b000));
		send_tick(pins_for(3'b111));
		send_tick(pins_for(3'b111));
		send_tick(pins_for(3'b111));
		send_tick(pins_for(3'b000));
		send_tick(3'b000);
		send_tick(3'b111);
		wait_for_results();

		// zero thresholds: long fires on the first held tick after down, then super on every held tick
		write_setting(3'b111, 3'b111, 8'd0, 8'd0);
		repeat (5) send_tick(3'b111);
		send_tick(3'b000);
		repeat (3) send_tick(3'b001);
		send_tick(3'b000);
		wait_for_results();

		// only key 1 sampled, the others freeze
		write_setting(3'b010, 3'b111, 8'd0, 8'd0);
		send_tick(3'b010);
		send_tick(3'b111);
		send_tick(3'b101);
		send_tick(3'b000);
		wait_for_results();

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: begin en = 3'd7; pol = 3'd0; lng = 8'd1;   sup = 8'd1;   n = 120; busy_pct = 20; end
				1: begin en = 3'd7; pol = 3'd7; lng = 8'd255; sup = 8'd3;   n = 450; busy_pct = 10; end
				2: begin en = 3'd5; pol = 3'd3; lng = 8'd2;   sup = 8'd255; n = 450; busy_pct = 25; end
				3: begin en = 3'd0; pol = 3'd7; lng = 8'd0;   sup = 8'd0;   n = 60;  busy_pct = 20; end
				4: begin en = 3'd6; pol = 3'd5; lng = 8'd4;   sup = 8'd2;   n = 120; busy_pct = 0;  end
				5: begin en = 3'd7; pol = 3'd1; lng = 8'd3;   sup = 8'd0;   n = 120; busy_pct = 30; end
				6: begin
					en  = NUM_KEYS'($urandom);
					pol = NUM_KEYS'($urandom);
					lng = TICK_W'($urandom_range(1, 12));
					sup = TICK_W'($urandom_range(1, 12));
					n = 130; busy_pct = 15;
				end
				7: begin
					en = ENABLE_RST; pol = POLARITY_RST; lng = LONG_RST; sup = SUPER_RST;
					n = 200; busy_pct = 15;
				end
				default: begin
					en  = NUM_KEYS'($urandom);
					pol = NUM_KEYS'($urandom);
					lng = TICK_W'($urandom_range(0, 6));
					sup = TICK_W'($urandom_range(0, 6));
					n = 150; busy_pct = 0;
				end
			endcase
			write_setting(en, pol, lng, sup);
			for (int i = 0; i < n; i++) begin
				send_tick(next_pins());
				if (p == 5 && i == n / 2)
					wait_for_results();
			end
			wait_for_results();
		end

		repeat (4) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("tb_key_press_classifier passed");
		else
			$display("tb_key_press_classifier failed");
		$finish;
	end

endmodule
